/* src/two_level_cache_tag_lru_model_unit_macros.svh */
// -----------------------------------------------------------------------------
// Assertion macros for the two-level cache tag unit
// Shared property forms, clocked on clk and disabled while rst_n is low.
// -----------------------------------------------------------------------------
`ifndef TWO_LEVEL_CACHE_TAG_LRU_MODEL_UNIT_MACROS_SVH
`define TWO_LEVEL_CACHE_TAG_LRU_MODEL_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define TLC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define TLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tlc_pkg.sv */
// -----------------------------------------------------------------------------
// tlc_pkg
// Types, codes and default geometry for the two-level cache tag unit.
// -----------------------------------------------------------------------------
package tlc_pkg;

    localparam int L1_SETS_DEF   = 64;
    localparam int L1_WAYS_DEF   = 16;
    localparam int L2_SETS_DEF   = 64;
    localparam int L2_WAYS_DEF   = 16;
    localparam int ADDR_BITS_DEF = 13;

    localparam int ADDR_W   = 13;
    localparam int PC_W     = 13;
    localparam int STAMP_W  = 32;
    localparam int SETIDX_W = 6;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    localparam logic [1:0] EV_HIT   = 2'd0;
    localparam logic [1:0] EV_MISS  = 2'd1;
    localparam logic [1:0] EV_STORE = 2'd2;

    localparam logic [2:0] REG_L1_SIZE  = 3'd0;
    localparam logic [2:0] REG_L1_ASSOC = 3'd1;
    localparam logic [2:0] REG_L1_BLOCK = 3'd2;
    localparam logic [2:0] REG_L2_EN    = 3'd3;
    localparam logic [2:0] REG_L2_SIZE  = 3'd4;
    localparam logic [2:0] REG_L2_ASSOC = 3'd5;
    localparam logic [2:0] REG_L2_BLOCK = 3'd6;

    typedef enum logic [1:0] {
        T_IDLE,
        T_L1,
        T_OUT,
        T_L2
    } top_state_t;

    typedef enum logic [1:0] {
        L_CLEAR,
        L_IDLE,
        L_SCAN,
        L_WRITE
    } lvl_state_t;

    typedef struct packed {
        logic       start;
        logic [3:0] size_log2;
        logic [2:0] assoc_log2;
        logic [2:0] block_log2;
    } lvl_req_t;

    typedef struct packed {
        logic ready;
        logic done;
        logic hit;
    } lvl_rsp_t;

endpackage

/* src/two_level_cache_tag_lru_model_unit.sv */
// -----------------------------------------------------------------------------
// two_level_cache_tag_lru_model_unit
// Tag-only LRU model of a write-through L1 with an optional L2 behind it.
// -----------------------------------------------------------------------------
// Each level looked up reads the configured ways of the set one by one from its
// memory, then writes the entry back; each result then goes to the output register.
// A new access is taken only once the previous one has left the last level it
// looks up; each level memory has a single read port.
// After reset each level clears its memory, all SETS * WAYS entries (1024 by
// default), during which no access is taken; configuration writes are taken.
module two_level_cache_tag_lru_model_unit #(
    parameter int L1_SETS   = tlc_pkg::L1_SETS_DEF,
    parameter int L1_WAYS   = tlc_pkg::L1_WAYS_DEF,
    parameter int L2_SETS   = tlc_pkg::L2_SETS_DEF,
    parameter int L2_WAYS   = tlc_pkg::L2_WAYS_DEF,
    parameter int ADDR_BITS = tlc_pkg::ADDR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // addr [12:0], pc [25:13], zero [31:26]
    input  logic [0:0]  s_tuser,   // op [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pc_out [12:0], addr_out [25:13], set_index [31:26]
    output logic [2:0]  m_tuser,   // level [0], event_res [2:1]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    localparam int L1_SET_W = (L1_SETS > 1) ? $clog2(L1_SETS) : 1;
    localparam int L2_SET_W = (L2_SETS > 1) ? $clog2(L2_SETS) : 1;
    localparam logic [tlc_pkg::ADDR_W-1:0] AMASK = (ADDR_BITS >= tlc_pkg::ADDR_W) ? '1 :
        tlc_pkg::ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

    logic [3:0] l1_size_reg;
    logic [2:0] l1_assoc_reg;
    logic [2:0] l1_block_reg;
    logic       l2_en_reg;
    logic [3:0] l2_size_reg;
    logic [2:0] l2_assoc_reg;
    logic [2:0] l2_block_reg;

    tlc_pkg::top_state_t state_reg, state_next;

    logic [tlc_pkg::STAMP_W-1:0] clock_reg, clock_next;
    logic                        op_reg, op_next;
    logic [tlc_pkg::ADDR_W-1:0]  addr_reg, addr_next;
    logic [tlc_pkg::PC_W-1:0]    pc_reg, pc_next;
    logic                        res_level_reg, res_level_next;
    logic [1:0]                  res_ev_reg, res_ev_next;
    logic [tlc_pkg::SETIDX_W-1:0] res_set_reg, res_set_next;
    logic                        res_last_reg, res_last_next;

    logic                         m_valid_reg, m_valid_next;
    logic [31:0]                  m_data_reg, m_data_next;
    logic [2:0]                   m_user_reg, m_user_next;
    logic                         m_last_reg, m_last_next;

    tlc_pkg::lvl_req_t l1_req, l2_req;
    tlc_pkg::lvl_rsp_t l1_rsp, l2_rsp;
    logic [L1_SET_W-1:0] l1_set;
    logic [L2_SET_W-1:0] l2_set;

    logic                       acc;
    logic                       slot_free;
    logic [tlc_pkg::ADDR_W-1:0] in_addr;

    assign cfg_ready = 1'b1;
    assign in_addr   = s_tdata[tlc_pkg::ADDR_W-1:0] & AMASK;
    assign s_tready  = (state_reg == tlc_pkg::T_IDLE) && l1_rsp.ready && l2_rsp.ready;
    assign acc       = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_size_reg  <= 4'd3;
            l1_assoc_reg <= 3'd0;
            l1_block_reg <= 3'd0;
            l2_en_reg    <= 1'b0;
            l2_size_reg  <= 4'd5;
            l2_assoc_reg <= 3'd0;
            l2_block_reg <= 3'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tlc_pkg::REG_L1_SIZE:  l1_size_reg  <= cfg_data;
                tlc_pkg::REG_L1_ASSOC: l1_assoc_reg <= cfg_data[2:0];
                tlc_pkg::REG_L1_BLOCK: l1_block_reg <= cfg_data[2:0];
                tlc_pkg::REG_L2_EN:    l2_en_reg    <= cfg_data[0];
                tlc_pkg::REG_L2_SIZE:  l2_size_reg  <= cfg_data;
                tlc_pkg::REG_L2_ASSOC: l2_assoc_reg <= cfg_data[2:0];
                tlc_pkg::REG_L2_BLOCK: l2_block_reg <= cfg_data[2:0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tlc_pkg::T_IDLE;
            clock_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clock_reg   <= clock_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        addr_reg      <= addr_next;
        pc_reg        <= pc_next;
        res_level_reg <= res_level_next;
        res_ev_reg    <= res_ev_next;
        res_set_reg   <= res_set_next;
        res_last_reg  <= res_last_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
        m_last_reg    <= m_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clock_next     = clock_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        pc_next        = pc_reg;
        res_level_next = res_level_reg;
        res_ev_next    = res_ev_reg;
        res_set_next   = res_set_reg;
        res_last_next  = res_last_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        m_last_next    = m_last_reg;

        l1_req.start      = 1'b0;
        l1_req.size_log2  = l1_size_reg;
        l1_req.assoc_log2 = l1_assoc_reg;
        l1_req.block_log2 = l1_block_reg;
        l2_req.start      = 1'b0;
        l2_req.size_log2  = l2_size_reg;
        l2_req.assoc_log2 = l2_assoc_reg;
        l2_req.block_log2 = l2_block_reg;

        case (state_reg)
            tlc_pkg::T_IDLE:
            begin
                if (acc)
                begin
                    op_next      = s_tuser[0];
                    addr_next    = in_addr;
                    pc_next      = s_tdata[2*tlc_pkg::ADDR_W-1:tlc_pkg::ADDR_W];
                    clock_next   = clock_reg + tlc_pkg::STAMP_W'(1);
                    l1_req.start = 1'b1;
                    state_next   = tlc_pkg::T_L1;
                end
            end
            tlc_pkg::T_L1:
            begin
                if (l1_rsp.done)
                begin
                    res_level_next = 1'b0;
                    res_set_next   = tlc_pkg::SETIDX_W'(l1_set);
                    res_last_next  = ((op_reg == tlc_pkg::OP_LOAD) && l1_rsp.hit) || !l2_en_reg;
                    if (op_reg == tlc_pkg::OP_STORE)
                    begin
                        res_ev_next = tlc_pkg::EV_STORE;
                    end
                    else
                    begin
                        res_ev_next = l1_rsp.hit ? tlc_pkg::EV_HIT : tlc_pkg::EV_MISS;
                    end
                    state_next = tlc_pkg::T_OUT;
                end
            end
            tlc_pkg::T_OUT:
            begin
                // hold the result until the output register can take it
                if (slot_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {res_set_reg, addr_reg, pc_reg};
                    m_user_next  = {res_ev_reg, res_level_reg};
                    m_last_next  = res_last_reg;
                    if (res_last_reg)
                    begin
                        state_next = tlc_pkg::T_IDLE;
                    end
                    else
                    begin
                        l2_req.start = 1'b1;
                        state_next   = tlc_pkg::T_L2;
                    end
                end
            end
            tlc_pkg::T_L2:
            begin
                if (l2_rsp.done)
                begin
                    res_level_next = 1'b1;
                    res_set_next   = tlc_pkg::SETIDX_W'(l2_set);
                    res_last_next  = 1'b1;
                    if (op_reg == tlc_pkg::OP_STORE)
                    begin
                        res_ev_next = tlc_pkg::EV_STORE;
                    end
                    else
                    begin
                        res_ev_next = l2_rsp.hit ? tlc_pkg::EV_HIT : tlc_pkg::EV_MISS;
                    end
                    state_next = tlc_pkg::T_OUT;
                end
            end
            default:
            begin
                state_next = tlc_pkg::T_IDLE;
            end
        endcase
    end

    tlc_level #(
        .SETS (L1_SETS),
        .WAYS (L1_WAYS)
    ) u_l1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (l1_req),
        .addr    (in_addr),
        .now     (clock_reg + tlc_pkg::STAMP_W'(1)),
        .rsp     (l1_rsp),
        .set_idx (l1_set)
    );

    tlc_level #(
        .SETS (L2_SETS),
        .WAYS (L2_WAYS)
    ) u_l2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (l2_req),
        .addr    (addr_reg),
        .now     (clock_reg),
        .rsp     (l2_rsp),
        .set_idx (l2_set)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

`include "two_level_cache_tag_lru_model_unit_macros.svh"

    `TLC_ASSERT_NEXT(a_busy_after_accept, acc, !s_tready, "input taken while an access runs")
    `TLC_ASSERT_SAME(a_one_level_done, l1_rsp.done, !l2_rsp.done, "both levels finished at once")
    `TLC_ASSERT_SAME(a_l2_only_enabled, m_tvalid && m_tuser[0], l2_en_reg,
        "second level result with second level off")

endmodule

/* src/tlc_level.sv */
// -----------------------------------------------------------------------------
// tlc_level
// One cache level: tag/stamp memory with a way-by-way lookup and LRU scan.
// -----------------------------------------------------------------------------
module tlc_level #(
    parameter int SETS = tlc_pkg::L1_SETS_DEF,
    parameter int WAYS = tlc_pkg::L1_WAYS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tlc_pkg::lvl_req_t             req,
    input  logic [tlc_pkg::ADDR_W-1:0]    addr,
    input  logic [tlc_pkg::STAMP_W-1:0]   now,
    output tlc_pkg::lvl_rsp_t             rsp,
    output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] set_idx
);

    localparam int SET_W      = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int SETS_FLOOR = $clog2(SETS + 1) - 1;
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W      = $clog2(WAYS + 1);
    localparam int DEPTH      = SETS * WAYS;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ENTRY_W    = 1 + tlc_pkg::STAMP_W + tlc_pkg::ADDR_W;

    tlc_pkg::lvl_state_t state_reg, state_next;

    logic [SET_W-1:0]            set_reg, set_next;
    logic [tlc_pkg::ADDR_W-1:0]  tag_reg, tag_next;
    logic [tlc_pkg::STAMP_W-1:0] now_reg, now_next;
    logic [CNT_W-1:0]            ways_reg, ways_next;
    logic [CNT_W-1:0]            rd_cnt_reg, rd_cnt_next;
    logic                        pend_reg, pend_next;
    logic [WAY_W-1:0]            pend_way_reg, pend_way_next;
    logic                        hit_reg, hit_next;
    logic [WAY_W-1:0]            hit_way_reg, hit_way_next;
    logic [WAY_W-1:0]            vic_reg, vic_next;
    logic [tlc_pkg::STAMP_W-1:0] vstamp_reg, vstamp_next;
    logic [IDX_W:0]              clr_reg, clr_next;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]   raddr;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               we;

    // Geometry decode for the incoming address
    logic signed [5:0]          e_s;
    logic [3:0]                 sl;
    logic [7:0]                 ways_full;
    logic [CNT_W-1:0]           ways_n;
    logic [tlc_pkg::ADDR_W-1:0] blk;
    logic [tlc_pkg::ADDR_W-1:0] set_mask;

    logic                        e_valid;
    logic [tlc_pkg::STAMP_W-1:0] e_stamp;
    logic [tlc_pkg::ADDR_W-1:0]  e_tag;

    function automatic logic [IDX_W-1:0] ent_idx(logic [SET_W-1:0] s, logic [WAY_W-1:0] w);
        ent_idx = IDX_W'(int'(s) * WAYS + int'(w));
    endfunction

    always_comb
    begin
        e_s = $signed({2'b00, req.size_log2}) - $signed({3'b000, req.block_log2})
            - $signed({3'b000, req.assoc_log2});
        if (e_s < 0)
        begin
            sl = 4'd0;
        end
        else if (e_s > 6'(SETS_FLOOR))
        begin
            sl = 4'(SETS_FLOOR);
        end
        else
        begin
            sl = e_s[3:0];
        end
        ways_full = 8'd1 << req.assoc_log2;
        ways_n    = (ways_full > 8'(WAYS)) ? CNT_W'(WAYS) : CNT_W'(ways_full);
        blk       = addr >> req.block_log2;
        set_mask  = (tlc_pkg::ADDR_W'(1) << sl) - tlc_pkg::ADDR_W'(1);
    end

    assign e_valid = rd_data_reg[ENTRY_W-1];
    assign e_stamp = rd_data_reg[ENTRY_W-2 -: tlc_pkg::STAMP_W];
    assign e_tag   = rd_data_reg[tlc_pkg::ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tlc_pkg::L_CLEAR;
            clr_reg    <= '0;
            pend_reg   <= 1'b0;
            rd_cnt_reg <= '0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            pend_reg   <= pend_next;
            rd_cnt_reg <= rd_cnt_next;
            hit_reg    <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_reg      <= set_next;
        tag_reg      <= tag_next;
        now_reg      <= now_next;
        ways_reg     <= ways_next;
        pend_way_reg <= pend_way_next;
        hit_way_reg  <= hit_way_next;
        vic_reg      <= vic_next;
        vstamp_reg   <= vstamp_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        set_next      = set_reg;
        tag_next      = tag_reg;
        now_next      = now_reg;
        ways_next     = ways_reg;
        rd_cnt_next   = rd_cnt_reg;
        pend_next     = 1'b0;
        pend_way_next = pend_way_reg;
        hit_next      = hit_reg;
        hit_way_next  = hit_way_reg;
        vic_next      = vic_reg;
        vstamp_next   = vstamp_reg;
        clr_next      = clr_reg;
        raddr         = ent_idx(set_reg, rd_cnt_reg[WAY_W-1:0]);
        waddr         = clr_reg[IDX_W-1:0];
        wdata         = '0;
        we            = 1'b0;
        rsp.ready     = 1'b0;
        rsp.done      = 1'b0;
        rsp.hit       = hit_reg;

        case (state_reg)
            tlc_pkg::L_CLEAR:
            begin
                we       = 1'b1;
                clr_next = clr_reg + (IDX_W + 1)'(1);
                if (clr_reg == (IDX_W + 1)'(DEPTH - 1))
                begin
                    state_next = tlc_pkg::L_IDLE;
                end
            end
            tlc_pkg::L_IDLE:
            begin
                rsp.ready = 1'b1;
                if (req.start)
                begin
                    set_next    = SET_W'(blk & set_mask);
                    tag_next    = blk >> sl;
                    now_next    = now;
                    ways_next   = ways_n;
                    rd_cnt_next = '0;
                    hit_next    = 1'b0;
                    state_next  = tlc_pkg::L_SCAN;
                end
            end
            tlc_pkg::L_SCAN:
            begin
                // issue one way per cycle, check the way read last cycle
                if (rd_cnt_reg < ways_reg)
                begin
                    pend_next     = 1'b1;
                    pend_way_next = rd_cnt_reg[WAY_W-1:0];
                    rd_cnt_next   = rd_cnt_reg + CNT_W'(1);
                end
                if (pend_reg)
                begin
                    if (e_valid && (e_tag == tag_reg) && !hit_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_way_next = pend_way_reg;
                    end
                    if ((pend_way_reg == '0) || !e_valid || (e_stamp < vstamp_reg))
                    begin
                        vic_next    = pend_way_reg;
                        vstamp_next = e_stamp;
                    end
                    if (CNT_W'(pend_way_reg) == ways_reg - CNT_W'(1))
                    begin
                        state_next = tlc_pkg::L_WRITE;
                    end
                end
            end
            tlc_pkg::L_WRITE:
            begin
                we         = 1'b1;
                waddr      = ent_idx(set_reg, hit_reg ? hit_way_reg : vic_reg);
                wdata      = {1'b1, now_reg, tag_reg};
                rsp.done   = 1'b1;
                state_next = tlc_pkg::L_IDLE;
            end
            default:
            begin
                state_next = tlc_pkg::L_IDLE;
            end
        endcase
    end

    assign set_idx = set_reg;

endmodule
